// ----- sv/pfv_pkg.sv -----
// Shared widths, stage counts and register indexes for the pair force kernel.
// Used by pfv_isqrt, pfv_div and pair_force_velocity_kernel; depends on nothing.
`default_nettype none

package pfv_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned GainW    = 32;
  localparam int unsigned RadW     = 31;
  localparam int unsigned DdW      = 64;
  localparam int unsigned RootW    = DdW / 2;
  localparam int unsigned MagW     = GainW + RadW;
  localparam int unsigned AccW     = MagW + 1;
  localparam int unsigned R2W      = 2 * RadW;
  localparam int unsigned CfgAddrW = 2;

  // One result bit per stage in both iterative units.
  localparam int unsigned SqrtStages = RootW;
  localparam int unsigned SqrtRemW   = RootW + 3;
  localparam int unsigned DivStages  = MagW;
  localparam int unsigned DivRemW    = RadW + 1;

  localparam int unsigned InDataW  = 10 * CoordW;
  localparam int unsigned OutDataW = 4 * CoordW;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_NEAR_RADIUS = 2'd0,
    CFG_MID_RADIUS  = 2'd1,
    CFG_MAX_RADIUS  = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- sv/pfv_isqrt.sv -----
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Depends on pfv_pkg.
`default_nettype none

module pfv_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [pfv_pkg::DdW-1:0]    rad_i,
  output logic [pfv_pkg::RootW-1:0]  root_o
);
  import pfv_pkg::*;

  logic [SqrtRemW-1:0] rem_q   [SqrtStages];
  logic [SqrtRemW-1:0] rem_d   [SqrtStages];
  logic [RootW-1:0]    root_q  [SqrtStages];
  logic [RootW-1:0]    root_d  [SqrtStages];
  logic [DdW-1:0]      val_q   [SqrtStages-1];
  logic [DdW-1:0]      val_d   [SqrtStages-1];
  logic [SqrtRemW-1:0] rem_in  [SqrtStages];
  logic [RootW-1:0]    root_in [SqrtStages];
  logic [DdW-1:0]      val_in  [SqrtStages];
  logic [SqrtRemW-1:0] rem_sh  [SqrtStages];
  logic [SqrtRemW-1:0] trial   [SqrtStages];
  logic                take    [SqrtStages];

  always_comb begin
    for (int k = 0; k < SqrtStages; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        val_in[k]  = rad_i;
      end else begin
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
        val_in[k]  = val_q[k-1];
      end
      // Bring down the next two bits and try the odd trial value.
      rem_sh[k] = {rem_in[k][SqrtRemW-3:0], val_in[k][DdW-1 -: 2]};
      trial[k]  = {1'b0, root_in[k], 2'b01};
      take[k]   = (rem_sh[k] >= trial[k]);
      rem_d[k]  = take[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
      root_d[k] = {root_in[k][RootW-2:0], take[k]};
      if (k < SqrtStages - 1) begin
        val_d[k] = {val_in[k][DdW-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SqrtStages; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      for (int k = 0; k < SqrtStages - 1; k++) begin
        val_q[k] <= val_d[k];
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

`default_nettype wire

// ----- sv/pfv_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on pfv_pkg.
`default_nettype none

module pfv_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pfv_pkg::MagW-1:0]  num_i,
  input  logic [pfv_pkg::RadW-1:0]  den_i,
  output logic [pfv_pkg::MagW-1:0]  quot_o
);
  import pfv_pkg::*;

  logic [DivRemW-1:0] rem_q  [DivStages-1];
  logic [DivRemW-1:0] rem_d  [DivStages-1];
  logic [RadW-1:0]    den_q  [DivStages-1];
  logic [MagW-1:0]    nq_q   [DivStages];
  logic [MagW-1:0]    nq_d   [DivStages];
  logic [DivRemW-1:0] rem_in [DivStages];
  logic [RadW-1:0]    den_in [DivStages];
  logic [MagW-1:0]    nq_in  [DivStages];
  logic [DivRemW-1:0] rem_sh [DivStages];
  logic               take   [DivStages];

  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        rem_in[k] = '0;
        den_in[k] = den_i;
        nq_in[k]  = num_i;
      end else begin
        rem_in[k] = rem_q[k-1];
        den_in[k] = den_q[k-1];
        nq_in[k]  = nq_q[k-1];
      end
      // The dividend shifts out at the top while quotient bits shift in below.
      rem_sh[k] = {rem_in[k][DivRemW-2:0], nq_in[k][MagW-1]};
      take[k]   = (rem_sh[k] >= {1'b0, den_in[k]});
      nq_d[k]   = {nq_in[k][MagW-2:0], take[k]};
      if (k < DivStages - 1) begin
        rem_d[k] = take[k] ? (rem_sh[k] - {1'b0, den_in[k]}) : rem_sh[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        nq_q[k] <= nq_d[k];
      end
      for (int k = 0; k < DivStages - 1; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quot_o = nq_q[DivStages-1];

endmodule

`default_nettype wire

// ----- sv/pair_force_velocity_kernel.sv -----
// Top level of the pair force kernel: offsets, squared distance, force law and deltas.
// Depends on pfv_pkg, pfv_isqrt and pfv_div.
//
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one particle pair: positions and both gain sets
//  m_axis    | out       | four velocity deltas, in_range flag in tuser
//  cfg       | in        | radius registers, write only
//
// One pair may enter every cycle while m_axis is not stalled; on its way each pair
// passes 4 offset/distance stages, 32 square root stages, 3 force stages,
// 63 divider stages and 3 scaling stages, the last of them the output register.
// A stall on m_axis freezes the whole pipeline, so s_axis_tready is low
// exactly while a result waits and is not taken. Reset clears the valid bits
// and the radius registers.
`default_nettype none

module pair_force_velocity_kernel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_x, first_y, second_x, second_y, first_near_gain, first_mid_gain,
  // first_far_gain, second_near_gain, second_mid_gain, second_far_gain
  input  logic [pfv_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // first_dvx, first_dvy, second_dvx, second_dvy
  output logic [pfv_pkg::OutDataW-1:0]   m_axis_tdata,
  // in_range
  output logic                           m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [pfv_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [pfv_pkg::RadW-1:0]       cfg_wdata_i
);
  import pfv_pkg::*;

  typedef struct packed {
    logic signed [GainW-1:0] fn;
    logic signed [GainW-1:0] fm;
    logic signed [GainW-1:0] ff;
    logic signed [GainW-1:0] sn;
    logic signed [GainW-1:0] sm;
    logic signed [GainW-1:0] sf;
  } gains_t;

  typedef struct packed {
    logic                     valid;
    logic                     in_range;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
    gains_t                   g;
  } sq_side_t;

  typedef struct packed {
    logic                     valid;
    logic                     in_range;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
    logic                     neg_p;
    logic                     neg_q;
  } dv_side_t;

  function automatic logic [CoordW-1:0] prod_hi(input logic [CoordW-1:0] a_lo,
                                                input logic signed [CoordW-1:0] b);
    logic signed [2*CoordW:0] p;
    p = $signed({1'b0, a_lo}) * b;
    return p[2*CoordW-1:CoordW];
  endfunction

  function automatic logic [CoordW-1:0] prod_lo(input logic [CoordW-1:0] a_hi,
                                                input logic [CoordW-1:0] b);
    logic [CoordW-1:0] p;
    p = a_hi * b;
    return p;
  endfunction

  logic en;

  // Configuration.
  logic [RadW-1:0] near_q, mid_q, max_q;
  logic [R2W-1:0]  rmax2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q  <= '0;
      mid_q   <= '0;
      max_q   <= '0;
      rmax2_q <= '0;
    end else begin
      rmax2_q <= R2W'(max_q) * R2W'(max_q);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_NEAR_RADIUS: near_q <= cfg_wdata_i;
          CFG_MID_RADIUS:  mid_q  <= cfg_wdata_i;
          CFG_MAX_RADIUS:  max_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Input fields.
  logic signed [CoordW-1:0] in_fx, in_fy, in_sx, in_sy;
  gains_t                   in_g;

  assign in_fx   = s_axis_tdata[0*CoordW +: CoordW];
  assign in_fy   = s_axis_tdata[1*CoordW +: CoordW];
  assign in_sx   = s_axis_tdata[2*CoordW +: CoordW];
  assign in_sy   = s_axis_tdata[3*CoordW +: CoordW];
  assign in_g.fn = s_axis_tdata[4*CoordW +: GainW];
  assign in_g.fm = s_axis_tdata[5*CoordW +: GainW];
  assign in_g.ff = s_axis_tdata[6*CoordW +: GainW];
  assign in_g.sn = s_axis_tdata[7*CoordW +: GainW];
  assign in_g.sm = s_axis_tdata[8*CoordW +: GainW];
  assign in_g.sf = s_axis_tdata[9*CoordW +: GainW];

  // Valid bits of the stages outside the two iterative units.
  logic v1_q, v2_q, v3_q, v4_q, f1_v_q, f2_v_q, f3_v_q, a_v_q, m_v_q, out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;

  // Offsets, magnitudes, squares and squared distance.
  logic signed [CoordW-1:0] dx1_q, dy1_q, dx2_q, dy2_q, dx3_q, dy3_q, dx4_q, dy4_q;
  gains_t                   g1_q, g2_q, g3_q, g4_q;
  logic [CoordW-1:0]        adx2_q, ady2_q;
  logic [DdW-1:0]           sqx3_q, sqy3_q, dd4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q  <= in_sx - in_fx;
      dy1_q  <= in_sy - in_fy;
      g1_q   <= in_g;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      g2_q   <= g1_q;
      adx2_q <= dx1_q[CoordW-1] ? -dx1_q : dx1_q;
      ady2_q <= dy1_q[CoordW-1] ? -dy1_q : dy1_q;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      g3_q   <= g2_q;
      sqx3_q <= DdW'(adx2_q) * DdW'(adx2_q);
      sqy3_q <= DdW'(ady2_q) * DdW'(ady2_q);
      dx4_q  <= dx3_q;
      dy4_q  <= dy3_q;
      g4_q   <= g3_q;
      dd4_q  <= sqx3_q + sqy3_q;
    end
  end

  // Square root, with the pair's other fields in a matching delay line.
  logic [RootW-1:0] root;
  sq_side_t         sq_side_q [SqrtStages];
  sq_side_t         sq_entry;

  pfv_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (dd4_q),
    .root_o (root)
  );

  always_comb begin
    sq_entry.valid    = v4_q;
    sq_entry.in_range = (dd4_q != '0) && (dd4_q <= DdW'(rmax2_q));
    sq_entry.dx       = dx4_q;
    sq_entry.dy       = dy4_q;
    sq_entry.g        = g4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtStages; k++) begin
        sq_side_q[k] <= '0;
      end
    end else if (en) begin
      sq_side_q[0] <= sq_entry;
      for (int k = 1; k < SqrtStages; k++) begin
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  // Force law: band choice, gain magnitude, then gain times distance term.
  sq_side_t                 sq_out;
  logic [RadW-1:0]          d_now;
  logic                     band_far, band_mid;
  logic                     f1_inr_q, f2_inr_q, f3_inr_q;
  logic signed [CoordW-1:0] f1_dx_q, f1_dy_q, f2_dx_q, f2_dy_q, f3_dx_q, f3_dy_q;
  logic [RadW-1:0]          f1_d_q, f2_d_q, f3_d_q, f1_diff_q, f2_diff_q;
  logic signed [GainW-1:0]  f1_gp_q, f1_gq_q;
  logic [GainW-1:0]         f2_gp_q, f2_gq_q;
  logic                     f2_np_q, f2_nq_q, f3_np_q, f3_nq_q;
  logic [MagW-1:0]          f3_mp_q, f3_mq_q;

  assign sq_out   = sq_side_q[SqrtStages-1];
  assign d_now    = root[RadW-1:0];
  assign band_far = (d_now >= mid_q);
  assign band_mid = (d_now >= near_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_inr_q <= sq_out.in_range;
      f1_dx_q  <= sq_out.dx;
      f1_dy_q  <= sq_out.dy;
      f1_d_q   <= d_now;
      if (band_far) begin
        f1_diff_q <= max_q - d_now;
        f1_gp_q   <= sq_out.g.ff;
        f1_gq_q   <= sq_out.g.sf;
      end else if (band_mid) begin
        f1_diff_q <= d_now - near_q;
        f1_gp_q   <= sq_out.g.fm;
        f1_gq_q   <= sq_out.g.sm;
      end else begin
        f1_diff_q <= near_q - d_now;
        f1_gp_q   <= sq_out.g.fn;
        f1_gq_q   <= sq_out.g.sn;
      end

      f2_inr_q  <= f1_inr_q;
      f2_dx_q   <= f1_dx_q;
      f2_dy_q   <= f1_dy_q;
      f2_d_q    <= f1_d_q;
      f2_diff_q <= f1_diff_q;
      f2_np_q   <= f1_gp_q[GainW-1];
      f2_nq_q   <= f1_gq_q[GainW-1];
      f2_gp_q   <= f1_gp_q[GainW-1] ? -f1_gp_q : f1_gp_q;
      f2_gq_q   <= f1_gq_q[GainW-1] ? -f1_gq_q : f1_gq_q;

      f3_inr_q <= f2_inr_q;
      f3_dx_q  <= f2_dx_q;
      f3_dy_q  <= f2_dy_q;
      f3_d_q   <= f2_d_q;
      f3_np_q  <= f2_np_q;
      f3_nq_q  <= f2_nq_q;
      f3_mp_q  <= MagW'(f2_gp_q) * MagW'(f2_diff_q);
      f3_mq_q  <= MagW'(f2_gq_q) * MagW'(f2_diff_q);
    end
  end

  // Force magnitude over distance; the sign is put back afterwards, which
  // gives truncation toward zero.
  logic [MagW-1:0] quot_p, quot_q;
  dv_side_t        dv_side_q [DivStages];
  dv_side_t        dv_entry;
  dv_side_t        dv_out;

  pfv_div u_div_p (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (f3_mp_q),
    .den_i  (f3_d_q),
    .quot_o (quot_p)
  );

  pfv_div u_div_q (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (f3_mq_q),
    .den_i  (f3_d_q),
    .quot_o (quot_q)
  );

  always_comb begin
    dv_entry.valid    = f3_v_q;
    dv_entry.in_range = f3_inr_q;
    dv_entry.dx       = f3_dx_q;
    dv_entry.dy       = f3_dy_q;
    dv_entry.neg_p    = f3_np_q;
    dv_entry.neg_q    = f3_nq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivStages; k++) begin
        dv_side_q[k] <= '0;
      end
    end else if (en) begin
      dv_side_q[0] <= dv_entry;
      for (int k = 1; k < DivStages; k++) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  assign dv_out = dv_side_q[DivStages-1];

  // Signed accelerations, then bits 63..32 of accel times offset as two
  // partial products that are summed in the output register.
  logic [AccW-1:0]          a_p_q, a_q_q;
  logic                     a_inr_q, m_inr_q;
  logic signed [CoordW-1:0] a_dx_q, a_dy_q;
  logic [CoordW-1:0]        hpx_q, lpx_q, hpy_q, lpy_q, hqx_q, lqx_q, hqy_q, lqy_q;
  logic [CoordW-1:0]        sum_px, sum_py, sum_qx, sum_qy;
  logic [CoordW-1:0]        out_fdx_q, out_fdy_q, out_sdx_q, out_sdy_q;
  logic                     out_inr_q;

  assign sum_px = hpx_q + lpx_q;
  assign sum_py = hpy_q + lpy_q;
  assign sum_qx = hqx_q + lqx_q;
  assign sum_qy = hqy_q + lqy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_inr_q <= dv_out.in_range;
      a_dx_q  <= dv_out.dx;
      a_dy_q  <= dv_out.dy;
      a_p_q   <= dv_out.neg_p ? -AccW'(quot_p) : AccW'(quot_p);
      a_q_q   <= dv_out.neg_q ? -AccW'(quot_q) : AccW'(quot_q);

      m_inr_q <= a_inr_q;
      hpx_q   <= prod_hi(a_p_q[CoordW-1:0], a_dx_q);
      lpx_q   <= prod_lo(a_p_q[AccW-1:CoordW], a_dx_q);
      hpy_q   <= prod_hi(a_p_q[CoordW-1:0], a_dy_q);
      lpy_q   <= prod_lo(a_p_q[AccW-1:CoordW], a_dy_q);
      hqx_q   <= prod_hi(a_q_q[CoordW-1:0], a_dx_q);
      lqx_q   <= prod_lo(a_q_q[AccW-1:CoordW], a_dx_q);
      hqy_q   <= prod_hi(a_q_q[CoordW-1:0], a_dy_q);
      lqy_q   <= prod_lo(a_q_q[AccW-1:CoordW], a_dy_q);

      out_inr_q <= m_inr_q;
      out_fdx_q <= m_inr_q ? sum_px : '0;
      out_fdy_q <= m_inr_q ? sum_py : '0;
      out_sdx_q <= m_inr_q ? -sum_qx : '0;
      out_sdy_q <= m_inr_q ? -sum_qy : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
      f3_v_q  <= 1'b0;
      a_v_q   <= 1'b0;
      m_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      f1_v_q  <= sq_out.valid;
      f2_v_q  <= f1_v_q;
      f3_v_q  <= f2_v_q;
      a_v_q   <= dv_out.valid;
      m_v_q   <= a_v_q;
      out_v_q <= m_v_q;
    end
  end

  assign m_axis_tdata = {out_sdy_q, out_sdx_q, out_fdy_q, out_fdx_q};
  assign m_axis_tuser = out_inr_q;

  // A pair that reaches the force stages in range has a nonzero distance.
  a_dist_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_v_q && f1_inr_q |-> f1_d_q != '0)
    else $error("in-range pair reached the force stages with zero distance");

  // A skipped pair carries all-zero deltas.
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_inr_q |-> m_axis_tdata == '0)
    else $error("skipped pair produced nonzero deltas");

  // The stall stops every stage, so the valid bits hold while a result waits.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(f1_v_q) && $stable(a_v_q) && $stable(v4_q))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ----- test/tb_pair_force_velocity_kernel.sv -----
// Self-checking testbench for pair_force_velocity_kernel: radius setups, pair stream, checks.
// Depends on pfv_pkg and the kernel RTL; predicts each velocity delta set in place.
`timescale 1ns / 100ps
`default_nettype none

module tb_pair_force_velocity_kernel;
  import pfv_pkg::*;

  localparam int unsigned PipeDepth = 106;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] second_dvy;
    logic [31:0] second_dvx;
    logic [31:0] first_dvy;
    logic [31:0] first_dvx;
    logic        in_range;
  } delta_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = CFG_NEAR_RADIUS;
  logic [RadW-1:0] cfg_wdata_i = '0;

  logic [30:0] near_r, mid_r, max_r;
  delta_t expected_deltas[$];
  int errors = 0;
  int idle_cycles = 0;

  pair_force_velocity_kernel dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Floor square root of a 64-bit value, bit by bit.
  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0] r;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      logic [31:0] t;
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] accel(logic signed [31:0] gn, logic signed [31:0] gm,
                                               logic signed [31:0] gf, longint d);
    longint f;
    if (d >= longint'(mid_r)) f = longint'(gf) * (longint'(max_r) - d);
    else if (d >= longint'(near_r)) f = longint'(gm) * (d - longint'(near_r));
    else f = longint'(gn) * (longint'(near_r) - d);
    return f / d;
  endfunction

  function automatic logic [31:0] upper_product(logic signed [63:0] a, logic signed [31:0] b);
    logic [63:0] p;
    p = a * 64'(b);
    return p[63:32];
  endfunction

  function automatic delta_t predict_deltas(logic [InDataW-1:0] pair);
    logic [31:0] f[10];
    logic signed [31:0] dx, dy;
    logic [63:0] dd, r2, ax, ay;
    longint d;
    logic signed [63:0] ap, aq;
    delta_t res;
    for (int i = 0; i < 10; i++) f[i] = pair[32*i +: 32];
    dx = f[2] - f[0];
    dy = f[3] - f[1];
    ax = dx < 0 ? -64'(dx) : 64'(dx);
    ay = dy < 0 ? -64'(dy) : 64'(dy);
    dd = ax * ax + ay * ay;
    r2 = 64'(max_r) * 64'(max_r);
    res = '0;
    if (dd > r2 || dd == 0) return res;
    d = longint'(floor_root(dd));
    ap = accel(f[4], f[5], f[6], d);
    aq = accel(f[7], f[8], f[9], d);
    res.first_dvx = upper_product(ap, dx);
    res.first_dvy = upper_product(ap, dy);
    res.second_dvx = -upper_product(aq, dx);
    res.second_dvy = -upper_product(aq, dy);
    res.in_range = 1'b1;
    return res;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Holds one register write for one edge; the caller drops the enable.
  task automatic write_radius(cfg_reg_e idx, logic [30:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_NEAR_RADIUS: near_r = v;
      CFG_MID_RADIUS:  mid_r = v;
      CFG_MAX_RADIUS:  max_r = v;
      default: ;
    endcase
  endtask

  task automatic set_radii(logic [30:0] n, logic [30:0] m, logic [30:0] x);
    write_radius(CFG_NEAR_RADIUS, n);
    write_radius(CFG_MID_RADIUS, m);
    write_radius(CFG_MAX_RADIUS, x);
    cfg_we_i <= 1'b0;
  endtask

  // Idle period between phases: all results in, then let the pipe empty.
  task automatic wait_idle();
    while (expected_deltas.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  task automatic send_pair(logic [InDataW-1:0] pair, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pair;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_deltas.push_back(predict_deltas(pair));
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [InDataW-1:0] make_pair(logic [31:0] x1, logic [31:0] y1,
                                                   logic [31:0] x2, logic [31:0] y2);
    logic [InDataW-1:0] p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, y2, x2, y1, x1};
    return p;
  endfunction

  task automatic test_directed();
    logic [InDataW-1:0] p;
    set_radii(31'd100, 31'd300, 31'd1000);
    send_pair(make_pair(32'd5, 32'd5, 32'd5, 32'd5), 0);                  // coincident
    send_pair(make_pair(32'd0, 32'd0, 32'd3, 32'd4), 0);                  // near band
    send_pair(make_pair(32'd0, 32'd0, 32'd150, 32'd0), 0);                // mid band
    send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'd600), 0);                // far band
    send_pair(make_pair(32'd0, 32'd0, 32'd1000, 32'd0), 0);               // on the cutoff
    send_pair(make_pair(32'd0, 32'd0, 32'd1000, 32'd1), 0);               // just outside
    send_pair(make_pair(32'h7fffffff, 32'h80000000, 32'h80000005, 32'h7ffffff0), 0);
    p = make_pair(32'd0, 32'd0, 32'hfffffff0, 32'd7);
    p[InDataW-1:128] = {6{32'h80000000}};
    send_pair(p, 0);
    p[InDataW-1:128] = {6{32'h7fffffff}};
    send_pair(p, 0);
    send_pair(make_pair(32'h80000000, 32'h80000000, 32'h00000000, 32'h0), 0); // far apart
    end_burst();
    wait_idle();
    // Near radius above mid radius removes the mid band.
    set_radii(31'd500, 31'd200, 31'd900);
    send_pair(make_pair(32'd0, 32'd0, 32'd300, 32'd0), 0);
    send_pair(make_pair(32'd0, 32'd0, 32'd100, 32'd0), 0);
    end_burst();
    wait_idle();
    // Widest radii: the largest cutoff that the radius registers can hold.
    set_radii(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_pair(make_pair($urandom, $urandom, $urandom, $urandom), 0);
    send_pair(make_pair(32'd0, 32'd0, 32'h80000000, 32'h80000000), 0);
    send_pair(make_pair(32'd0, 32'd0, 32'd1, 32'd0), 0);
    end_burst();
    wait_idle();
    set_radii(31'd0, 31'd0, 31'd0);
    send_pair(make_pair(32'd0, 32'd0, 32'd1, 32'd0), 0);
    end_burst();
    wait_idle();
  endtask

  task automatic test_random(int count);
    logic [31:0] x, y, span, dx, dy;
    logic [30:0] n, m, r;
    for (int phase = 0; phase < 6; phase++) begin
      r = phase == 5 ? 31'h7fffffff : 31'($urandom_range(1, 1 << (4 + 5 * phase)));
      n = 31'($urandom_range(0, r));
      m = 31'($urandom_range(0, r));
      if (phase == 2) n = 31'h7fffffff;
      set_radii(n, m, r);
      for (int i = 0; i < count / 6; i++) begin
        x = $urandom;
        y = $urandom;
        // Mostly pairs inside the cutoff, some anywhere on the torus.
        if ($urandom_range(0, 9) < 8) begin
          span = 32'(r) / 2 + 1;
          dx = $urandom_range(0, span * 2) - span;
          dy = $urandom_range(0, span * 2) - span;
        end else begin
          dx = $urandom;
          dy = $urandom;
        end
        send_pair(make_pair(x, y, x + dx, y + dy), 1);
      end
      end_burst();
      wait_idle();
    end
  endtask

  // Result side: random stalls and the field checks.
  initial begin
    delta_t want, got;
    int g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      m_axis_tready <= (g == 0);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser};
        if (expected_deltas.size() == 0) begin
          $error("result with nothing expected: %h", got);
          errors++;
        end else begin
          want = expected_deltas.pop_front();
          if (got.first_dvx !== want.first_dvx) begin
            $error("first_dvx exp %h got %h", want.first_dvx, got.first_dvx); errors++;
          end
          if (got.first_dvy !== want.first_dvy) begin
            $error("first_dvy exp %h got %h", want.first_dvy, got.first_dvy); errors++;
          end
          if (got.second_dvx !== want.second_dvx) begin
            $error("second_dvx exp %h got %h", want.second_dvx, got.second_dvx); errors++;
          end
          if (got.second_dvy !== want.second_dvy) begin
            $error("second_dvy exp %h got %h", want.second_dvy, got.second_dvy); errors++;
          end
          if (got.in_range !== want.in_range) begin
            $error("in_range exp %b got %b", want.in_range, got.in_range); errors++;
          end
        end
      end
      if (g > 1) begin
        repeat (g - 1) begin
          @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; idle drain pauses are far shorter.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_pair_force_velocity_kernel: errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1950);
    wait_idle();
    if (errors == 0 && expected_deltas.size() == 0) begin
      $display("tb_pair_force_velocity_kernel: clean");
    end else begin
      $display("tb_pair_force_velocity_kernel: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- pair_force_velocity_kernel.f -----
sv/pfv_pkg.sv
sv/pfv_isqrt.sv
sv/pfv_div.sv
sv/pair_force_velocity_kernel.sv
test/tb_pair_force_velocity_kernel.sv
